// ===== design/pscn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscn_pkg
// Shared types, codes and constants of the pedal sensor calibrate and
// normalize unit.
// ----------------------------------------------------------------------------
package pscn_pkg;

  // field widths
  localparam int RAW_W    = 16;
  localparam int TIME_W   = 32;
  localparam int FRAC_W   = 17;
  localparam int OP_W     = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF        = 16;
  localparam int THROTTLE_WINDOW_US_DEF = 5000000;
  localparam int BRAKE_WINDOW_US_DEF    = 3000000;

  // full travel in Q1.16
  localparam logic [FRAC_W-1:0] FULL_TRAVEL = 17'h10000;
  // largest fraction not above one tenth of full travel, floor(65536 / 10)
  localparam logic [FRAC_W-1:0] TENTH_LIMIT = 17'd6553;
  // reset value of the upper spec limits
  localparam logic [RAW_W-1:0]  SPEC_MAX_RESET = 16'hFFFF;

  // operation codes
  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CAL_START = 2'd1;
  localparam logic [OP_W-1:0] OP_CAL_CLEAR = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_PEDAL_KIND     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRIMARY_REV    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SECONDARY_REV  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PRIMARY_MIN    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PRIMARY_MAX    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SECONDARY_MIN  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SECONDARY_MAX  = 3'd6;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] time_us;
    logic [RAW_W-1:0]  primary_raw;
    logic [RAW_W-1:0]  secondary_raw;
  } pscn_in_t;

  // result transaction
  typedef struct packed {
    logic [FRAC_W-1:0] travel;
    logic [FRAC_W-1:0] primary_travel;
    logic [FRAC_W-1:0] secondary_travel;
    logic              brakes_on;
    logic              implausible;
    logic              in_range;
    logic              calibrated;
    logic              calibrating;
  } pscn_out_t;

  // fraction strictly above ten percent of full travel
  function automatic logic above_tenth(input logic [FRAC_W-1:0] q);
    return q > TENTH_LIMIT;
  endfunction

endpackage

// ===== design/pedal_sensor_calibrate_normalize_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_sensor_calibrate_normalize_unit
// Pedal position sensor calibration window, travel normalization with a
// shared serial divider, plausibility and range checks.
// ----------------------------------------------------------------------------
//  channel  | signals                                    | direction
//  ---------+--------------------------------------------+----------
//  item     | item_valid, item_ready, item (pscn_in_t)   | in
//  result   | result_valid, result_ready, result         | out
//  config   | psel, penable, pwrite, paddr, pwdata,      | in/out
//           | prdata, pready                             |
//
//  A command, or a sample before calibration, goes straight to the finish
//  step; a calibrated sample runs setup, load and divide once for a brake
//  and twice for a throttle, on a restoring divider that yields one quotient
//  bit per cycle and is shared by both sensors. A capped or zero fraction
//  skips its divide steps. Reset is synchronous; it clears flags and
//  calibration limits and returns the registers to their default values.
//  A new item is taken while the last result waits in the output register;
//  a stalled result holds the finish step until it is taken.
// ----------------------------------------------------------------------------
module pedal_sensor_calibrate_normalize_unit #(
  parameter int SAMPLE_BITS        = pscn_pkg::SAMPLE_BITS_DEF,
  parameter int THROTTLE_WINDOW_US = pscn_pkg::THROTTLE_WINDOW_US_DEF,
  parameter int BRAKE_WINDOW_US    = pscn_pkg::BRAKE_WINDOW_US_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // item channel
  input  logic                          item_valid,
  output logic                          item_ready,
  input  pscn_pkg::pscn_in_t            item,
  // result channel
  output logic                          result_valid,
  input  logic                          result_ready,
  output pscn_pkg::pscn_out_t           result,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pscn_pkg::ADDR_W-1:0]   paddr,
  input  logic [pscn_pkg::DATA_W-1:0]   pwdata,
  output logic [pscn_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam logic [pscn_pkg::RAW_W-1:0] SAMPLE_MASK =
    pscn_pkg::RAW_W'((33'd1 << SAMPLE_BITS) - 33'd1);
  localparam logic [pscn_pkg::TIME_W-1:0] THROTTLE_WIN =
    pscn_pkg::TIME_W'(THROTTLE_WINDOW_US);
  localparam logic [pscn_pkg::TIME_W-1:0] BRAKE_WIN =
    pscn_pkg::TIME_W'(BRAKE_WINDOW_US);

  typedef enum logic [2:0] {S_IDLE, S_SETUP, S_LOAD, S_DIV, S_FINISH} state_t;

  // configuration registers
  logic        pedal_kind;
  logic        prim_invert;
  logic        sec_invert;
  logic [15:0] primary_spec_min;
  logic [15:0] primary_spec_max;
  logic [15:0] secondary_spec_min;
  logic [15:0] secondary_spec_max;

  // calibration state
  logic [15:0] cal_min_primary, cal_max_primary;
  logic [15:0] cal_min_secondary, cal_max_secondary;
  logic [31:0] window_start;
  logic        calibrating_flag, calibrated_flag;
  logic [16:0] held_travel;

  // sequencer and shared divider
  state_t              state;
  pscn_pkg::pscn_in_t  item_q;
  logic                sel;
  logic [16:0]         num_q, den_q;
  logic [15:0]         rem, div_den, quo;
  logic [3:0]          cnt;
  logic [16:0]         pt, st;

  logic [15:0] praw, sraw;
  logic        brake;

  assign praw  = item_q.primary_raw & SAMPLE_MASK;
  assign sraw  = item_q.secondary_raw & SAMPLE_MASK;
  assign brake = pedal_kind;

  // configuration writes and reads
  logic                              cfg_write;
  logic [pscn_pkg::REG_IDX_W-1:0]    cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[pscn_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      pedal_kind         <= 1'b0;
      prim_invert        <= 1'b0;
      sec_invert         <= 1'b1;
      primary_spec_min   <= '0;
      primary_spec_max   <= pscn_pkg::SPEC_MAX_RESET;
      secondary_spec_min <= '0;
      secondary_spec_max <= pscn_pkg::SPEC_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        pscn_pkg::REG_PEDAL_KIND:    pedal_kind         <= pwdata[0];
        pscn_pkg::REG_PRIMARY_REV:   prim_invert        <= pwdata[0];
        pscn_pkg::REG_SECONDARY_REV: sec_invert         <= pwdata[0];
        pscn_pkg::REG_PRIMARY_MIN:   primary_spec_min   <= pwdata[15:0];
        pscn_pkg::REG_PRIMARY_MAX:   primary_spec_max   <= pwdata[15:0];
        pscn_pkg::REG_SECONDARY_MIN: secondary_spec_min <= pwdata[15:0];
        pscn_pkg::REG_SECONDARY_MAX: secondary_spec_max <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pscn_pkg::REG_PEDAL_KIND:    prdata = {31'd0, pedal_kind};
      pscn_pkg::REG_PRIMARY_REV:   prdata = {31'd0, prim_invert};
      pscn_pkg::REG_SECONDARY_REV: prdata = {31'd0, sec_invert};
      pscn_pkg::REG_PRIMARY_MIN:   prdata = {16'd0, primary_spec_min};
      pscn_pkg::REG_PRIMARY_MAX:   prdata = {16'd0, primary_spec_max};
      pscn_pkg::REG_SECONDARY_MIN: prdata = {16'd0, secondary_spec_min};
      pscn_pkg::REG_SECONDARY_MAX: prdata = {16'd0, secondary_spec_max};
      default:                     prdata = '0;
    endcase
  end

  assign item_ready = (state == S_IDLE);

  // setup: operand select, optional reverse, signed differences
  logic [15:0] raw_sel, lo_sel, hi_sel, v_sel;
  logic        rev_sel;
  logic [16:0] num_d, den_d;

  always_comb begin
    raw_sel = sel ? sraw : praw;
    rev_sel = sel ? sec_invert : prim_invert;
    lo_sel  = sel ? cal_min_secondary : cal_min_primary;
    hi_sel  = sel ? cal_max_secondary : cal_max_primary;
    if (!rev_sel) begin
      v_sel = raw_sel;
    end else if (raw_sel > hi_sel) begin
      v_sel = '0;
    end else begin
      v_sel = hi_sel - raw_sel;
    end
    num_d = {1'b0, v_sel} - {1'b0, lo_sel};
    den_d = {1'b0, hi_sel} - {1'b0, lo_sel};
  end

  // load: magnitudes and the zero and capped cases
  logic [16:0] an_full, ad_full;
  logic [15:0] an, ad;
  logic        frac_zero, frac_cap;

  always_comb begin
    an_full   = num_q[16] ? (17'd0 - num_q) : num_q;
    ad_full   = den_q[16] ? (17'd0 - den_q) : den_q;
    an        = an_full[15:0];
    ad        = ad_full[15:0];
    frac_zero = (den_q == '0) || (num_q == '0) || (num_q[16] != den_q[16]);
    frac_cap  = (an >= ad);
  end

  // divider step: one quotient bit a cycle
  logic [16:0] rem2, rem_sub;
  logic        div_ge;

  always_comb begin
    rem2    = {rem, 1'b0};
    div_ge  = rem2 >= {1'b0, div_den};
    rem_sub = div_ge ? (rem2 - {1'b0, div_den}) : rem2;
  end

  // fraction ready from either the load shortcut or the last divide step
  logic        frac_ready;
  logic [16:0] frac_val;

  always_comb begin
    frac_ready = 1'b0;
    frac_val   = '0;
    if (state == S_LOAD && (frac_zero || frac_cap)) begin
      frac_ready = 1'b1;
      frac_val   = frac_zero ? 17'd0 : pscn_pkg::FULL_TRAVEL;
    end else if (state == S_DIV && cnt == '0) begin
      frac_ready = 1'b1;
      frac_val   = {1'b0, quo[14:0], div_ge};
    end
  end

  // finish: travel, checks, calibration step and the result
  logic [17:0] pair_sum;
  logic [16:0] pair_diff;
  logic [31:0] elapsed;
  logic [31:0] win;
  logic [15:0] cmin_p_next, cmax_p_next, cmin_s_next, cmax_s_next;
  logic [31:0] wstart_next;
  logic        calibrating_next, calibrated_next;
  logic [16:0] held_next;
  logic        impl, rng;
  pscn_pkg::pscn_out_t res_next;

  always_comb begin
    pair_sum         = {1'b0, pt} + {1'b0, st};
    pair_diff        = (pt > st) ? (pt - st) : (st - pt);
    elapsed          = item_q.time_us - window_start;
    win              = brake ? BRAKE_WIN : THROTTLE_WIN;
    cmin_p_next      = cal_min_primary;
    cmax_p_next      = cal_max_primary;
    cmin_s_next      = cal_min_secondary;
    cmax_s_next      = cal_max_secondary;
    wstart_next      = window_start;
    calibrating_next = calibrating_flag;
    calibrated_next  = calibrated_flag;
    held_next        = held_travel;
    impl             = 1'b0;
    rng              = 1'b0;
    unique case (item_q.op)
      pscn_pkg::OP_SAMPLE: begin
        if (!brake) begin
          held_next = pair_sum[17:1];
          impl      = pscn_pkg::above_tenth(pair_diff);
        end else if (calibrated_flag) begin
          held_next = pt;
        end
        rng = (praw >= primary_spec_min) && (praw <= primary_spec_max);
        if (!brake && ((sraw < secondary_spec_min) || (sraw > secondary_spec_max))) begin
          rng = 1'b0;
        end
        // calibration window tracking or close
        if (calibrating_flag) begin
          if (elapsed < win) begin
            if (praw < cal_min_primary || cal_min_primary == '0) cmin_p_next = praw;
            if (praw > cal_max_primary) cmax_p_next = praw;
            if (!brake) begin
              if (sraw < cal_min_secondary || cal_min_secondary == '0) cmin_s_next = sraw;
              if (sraw > cal_max_secondary) cmax_s_next = sraw;
            end
          end else begin
            calibrating_next = 1'b0;
            calibrated_next  = 1'b1;
          end
        end
      end
      pscn_pkg::OP_CAL_START: begin
        calibrating_next = 1'b1;
        calibrated_next  = 1'b0;
        wstart_next      = item_q.time_us;
        cmin_p_next      = SAMPLE_MASK;
        cmax_p_next      = '0;
        cmin_s_next      = SAMPLE_MASK;
        cmax_s_next      = '0;
      end
      pscn_pkg::OP_CAL_CLEAR: begin
        calibrating_next = 1'b0;
        calibrated_next  = 1'b0;
        cmin_p_next      = '0;
        cmax_p_next      = '0;
        cmin_s_next      = '0;
        cmax_s_next      = '0;
      end
      default: ;
    endcase
    res_next.travel           = held_next;
    res_next.primary_travel   = brake ? 17'd0 : pt;
    res_next.secondary_travel = brake ? 17'd0 : st;
    res_next.brakes_on        = brake && pscn_pkg::above_tenth(held_next);
    res_next.implausible      = brake ? 1'b0 : impl;
    res_next.in_range         = rng;
    res_next.calibrated       = calibrated_next;
    res_next.calibrating      = calibrating_next;
  end

  // sequencer, state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      cal_min_primary   <= '0;
      cal_max_primary   <= '0;
      cal_min_secondary <= '0;
      cal_max_secondary <= '0;
      window_start      <= '0;
      calibrating_flag  <= 1'b0;
      calibrated_flag   <= 1'b0;
      held_travel       <= '0;
    end else begin
      // the finish step reloads the result register itself
      if (result_valid && result_ready && state != S_FINISH) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            item_q <= item;
            pt     <= '0;
            st     <= '0;
            sel    <= 1'b0;
            state  <= (item.op == pscn_pkg::OP_SAMPLE && calibrated_flag) ?
                      S_SETUP : S_FINISH;
          end
        end
        S_SETUP: begin
          num_q <= num_d;
          den_q <= den_d;
          state <= S_LOAD;
        end
        S_LOAD: begin
          rem     <= an;
          div_den <= ad;
          quo     <= '0;
          cnt     <= 4'd15;
          if (!frac_ready) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_sub[15:0];
          quo <= {quo[14:0], div_ge};
          cnt <= cnt - 4'd1;
        end
        S_FINISH: begin
          if (!result_valid || result_ready) begin
            result            <= res_next;
            result_valid      <= 1'b1;
            cal_min_primary   <= cmin_p_next;
            cal_max_primary   <= cmax_p_next;
            cal_min_secondary <= cmin_s_next;
            cal_max_secondary <= cmax_s_next;
            window_start      <= wstart_next;
            calibrating_flag  <= calibrating_next;
            calibrated_flag   <= calibrated_next;
            held_travel       <= held_next;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // store a finished fraction and move to the next sensor or finish
      if (frac_ready) begin
        if (sel) begin
          st <= frac_val;
        end else begin
          pt <= frac_val;
        end
        if (!sel && !brake) begin
          sel   <= 1'b1;
          state <= S_SETUP;
        end else begin
          state <= S_FINISH;
        end
      end
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(calibrating_flag && calibrated_flag))
    else $error("calibrating and calibrated both set");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < div_den))
    else $error("divider remainder not below divisor");

  a_travel_bounded: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.travel <= pscn_pkg::FULL_TRAVEL &&
                      result.primary_travel <= pscn_pkg::FULL_TRAVEL &&
                      result.secondary_travel <= pscn_pkg::FULL_TRAVEL))
    else $error("travel above full scale");

  a_brake_no_pair: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.brakes_on) |->
      (result.primary_travel == '0 && result.implausible == 1'b0))
    else $error("brake result carries throttle pair data");

endmodule
